// File: hdl/i2cm_pkg.sv
// Shared types, codes and constants of the I2C master byte engine.
package i2cm_pkg;

   // Operation codes on the request channel
   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_TICK  = 3'd4
   } op_type;

   // Classified request word, as queued between front and back
   typedef enum logic [2:0] {
      ITEM_START = 3'd0,
      ITEM_STOP  = 3'd1,
      ITEM_WRITE = 3'd2,
      ITEM_READ  = 3'd3,
      ITEM_TICK  = 3'd4,
      ITEM_NONE  = 3'd5
   } item_type;

   // Command latched while busy
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef struct packed {
      item_type   cls;
      logic [7:0] data_byte;
      logic       send_nack;
      logic       sda_in;
   } q_word_type;

   // Phase counts and landmarks
   localparam int PhaseW = 5;
   localparam logic [PhaseW-1:0] EdgePhases    = 5'd4;
   localparam logic [PhaseW-1:0] WritePhases   = 5'd27;
   localparam logic [PhaseW-1:0] ReadPhases    = 5'd19;
   localparam logic [PhaseW-1:0] WriteBitsEnd  = 5'd24;
   localparam logic [PhaseW-1:0] WriteLastBit  = 5'd23;
   localparam logic [PhaseW-1:0] WriteAckSample = 5'd25;
   localparam logic [PhaseW-1:0] WriteAckHold  = 5'd26;
   localparam logic [PhaseW-1:0] ReadBitsEnd   = 5'd16;
   localparam logic [PhaseW-1:0] ReadAckDrive  = 5'd16;
   localparam logic [PhaseW-1:0] ReadAckHigh   = 5'd17;
   localparam logic [7:0]        MsbMask       = 8'h80;

   localparam int QueueDepth = 2;

   // Number of bus phases of a command
   function automatic logic [PhaseW-1:0] phase_count(input cmd_type kind);
      logic [PhaseW-1:0] n;
      case (kind)
         CMD_START: n = EdgePhases;
         CMD_STOP:  n = EdgePhases;
         CMD_WRITE: n = WritePhases;
         CMD_READ:  n = ReadPhases;
         default:   n = ReadPhases;
      endcase
      return n;
   endfunction

   // Command carried by a command word
   function automatic cmd_type item_to_cmd(input item_type cls);
      cmd_type k;
      case (cls)
         ITEM_START: k = CMD_START;
         ITEM_STOP:  k = CMD_STOP;
         ITEM_WRITE: k = CMD_WRITE;
         ITEM_READ:  k = CMD_READ;
         default:    k = CMD_START;
      endcase
      return k;
   endfunction

endpackage

// File: hdl/i2cm_front.sv
// Request front end: handshake and classification of incoming words.
module i2cm_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_op,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_send_nack,
   input  logic                   req_sda_in,
   input  logic                   q_full,
   output logic                   push,
   output i2cm_pkg::q_word_type   push_word
);

   i2cm_pkg::item_type cls;

   // Classify the operation code
   always_comb begin
      case (i2cm_pkg::op_type'(req_op))
         i2cm_pkg::OP_START: cls = i2cm_pkg::ITEM_START;
         i2cm_pkg::OP_STOP:  cls = i2cm_pkg::ITEM_STOP;
         i2cm_pkg::OP_WRITE: cls = i2cm_pkg::ITEM_WRITE;
         i2cm_pkg::OP_READ:  cls = i2cm_pkg::ITEM_READ;
         i2cm_pkg::OP_TICK:  cls = i2cm_pkg::ITEM_TICK;
         default:            cls = i2cm_pkg::ITEM_NONE;
      endcase
   end

   // Accept whenever the queue has room
   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

   assign push_word.cls       = cls;
   assign push_word.data_byte = req_data_byte;
   assign push_word.send_nack = req_send_nack;
   assign push_word.sda_in    = req_sda_in;

endmodule

// File: hdl/i2cm_queue.sv
// Small FIFO of classified words between front end and bus engine.
module i2cm_queue #(
   parameter int Depth = i2cm_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  i2cm_pkg::q_word_type   push_word,
   input  logic                   pop,
   output i2cm_pkg::q_word_type   pop_word,
   output logic                   not_empty,
   output logic                   full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   i2cm_pkg::q_word_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CntW'(Depth));
   assign pop_word  = entries_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

endmodule

// File: hdl/i2cm_back.sv
// Bus engine: steps start, stop, write and read commands one phase per tick.
module i2cm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  i2cm_pkg::q_word_type   q_word,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_scl,
   output logic                   rsp_sda_out,
   output logic                   rsp_sda_oe,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic                   rsp_ack_ok,
   output logic [7:0]             rsp_read_data
);

   localparam int PW = i2cm_pkg::PhaseW;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]     phase_ff, phase_in;
   logic [1:0]        sub_ff, sub_in;
   i2cm_pkg::cmd_type kind_ff, kind_in;
   logic              busy_ff, busy_in;
   logic [7:0]        shift_ff, shift_in;
   logic              nack_ff, nack_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic              oe_ff, oe_in;
   logic              ack_ff, ack_in;
   logic [7:0]        rdata_ff, rdata_in;
   logic              done_ff, done_in;
   logic              edge_final;
   logic              line;

   // Take a word when the result slot is free or being drained
   assign pop          = q_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = pop | (rsp_valid_ff & rsp_stall);
   assign line         = q_word.sda_in;
   assign edge_final   = (kind_ff == i2cm_pkg::CMD_STOP);

   // One step of the engine per word
   always_comb begin
      phase_in = phase_ff;
      sub_in   = sub_ff;
      kind_in  = kind_ff;
      busy_in  = busy_ff;
      shift_in = shift_ff;
      nack_in  = nack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      oe_in    = oe_ff;
      ack_in   = ack_ff;
      rdata_in = rdata_ff;
      done_in  = 1'b0;
      if (!busy_ff) begin
         // Idle: latch a command
         if (q_word.cls == i2cm_pkg::ITEM_START || q_word.cls == i2cm_pkg::ITEM_STOP ||
             q_word.cls == i2cm_pkg::ITEM_WRITE || q_word.cls == i2cm_pkg::ITEM_READ) begin
            kind_in  = i2cm_pkg::item_to_cmd(q_word.cls);
            busy_in  = 1'b1;
            phase_in = '0;
            sub_in   = '0;
            if (q_word.cls == i2cm_pkg::ITEM_WRITE) begin
               shift_in = q_word.data_byte;
            end else if (q_word.cls == i2cm_pkg::ITEM_READ) begin
               shift_in = '0;
               nack_in  = q_word.send_nack;
            end
         end
      end else if (q_word.cls == i2cm_pkg::ITEM_TICK) begin
         if (phase_ff >= i2cm_pkg::phase_count(kind_ff)) begin
            // Last phase behind us: finish
            done_in = 1'b1;
            busy_in = 1'b0;
            if (kind_ff == i2cm_pkg::CMD_READ) begin
               rdata_in = shift_ff;
            end
         end else begin
            phase_in = phase_ff + 1'b1;
            case (kind_ff)
               i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP: begin
                  case (phase_ff)
                     5'd0: begin
                        oe_in  = 1'b1;
                        sda_in = ~edge_final;
                     end
                     5'd1:    scl_in = 1'b1;
                     5'd2:    sda_in = edge_final;
                     default: scl_in = 1'b0;
                  endcase
               end
               i2cm_pkg::CMD_WRITE: begin
                  if (phase_ff < i2cm_pkg::WriteBitsEnd) begin
                     // Three phases per bit
                     sub_in = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 1'b1;
                     case (sub_ff)
                        2'd0:    sda_in = |(shift_ff & i2cm_pkg::MsbMask);
                        2'd1:    scl_in = 1'b1;
                        default: begin
                           scl_in   = 1'b0;
                           shift_in = {shift_ff[6:0], 1'b0};
                           if (phase_ff == i2cm_pkg::WriteLastBit) begin
                              oe_in = 1'b0;
                           end
                        end
                     endcase
                  end else if (phase_ff == i2cm_pkg::WriteBitsEnd) begin
                     scl_in = 1'b1;
                  end else if (phase_ff == i2cm_pkg::WriteAckSample) begin
                     // Sample slave acknowledge
                     oe_in = 1'b1;
                     if (line) begin
                        scl_in   = 1'b0;
                        sda_in   = 1'b1;
                        ack_in   = 1'b0;
                        phase_in = i2cm_pkg::WritePhases;
                     end else begin
                        sda_in   = 1'b0;
                        ack_in   = 1'b1;
                        phase_in = i2cm_pkg::WriteAckHold;
                     end
                  end else begin
                     scl_in   = 1'b0;
                     phase_in = i2cm_pkg::WritePhases;
                  end
               end
               default: begin
                  // Read: two phases per bit, then the answer bit
                  if (phase_ff < i2cm_pkg::ReadBitsEnd) begin
                     if (!phase_ff[0]) begin
                        if (phase_ff == '0) begin
                           oe_in = 1'b0;
                        end
                        scl_in = 1'b1;
                     end else begin
                        shift_in = {shift_ff[6:0], line};
                        scl_in   = 1'b0;
                     end
                  end else if (phase_ff == i2cm_pkg::ReadAckDrive) begin
                     oe_in  = 1'b1;
                     sda_in = nack_ff;
                  end else if (phase_ff == i2cm_pkg::ReadAckHigh) begin
                     scl_in = 1'b1;
                  end else begin
                     scl_in = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         sub_ff       <= '0;
         kind_ff      <= i2cm_pkg::CMD_START;
         busy_ff      <= 1'b0;
         shift_ff     <= '0;
         nack_ff      <= 1'b0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b1;
         oe_ff        <= 1'b1;
         ack_ff       <= 1'b0;
         rdata_ff     <= '0;
         done_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            sub_ff   <= sub_in;
            kind_ff  <= kind_in;
            busy_ff  <= busy_in;
            shift_ff <= shift_in;
            nack_ff  <= nack_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            oe_ff    <= oe_in;
            ack_ff   <= ack_in;
            rdata_ff <= rdata_in;
            done_ff  <= done_in;
         end
      end
   end

   // State after the word doubles as the held result
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl       = scl_ff;
   assign rsp_sda_out   = sda_ff;
   assign rsp_sda_oe    = oe_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_ack_ok    = ack_ff;
   assign rsp_read_data = rdata_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done reported while still busy");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= i2cm_pkg::WritePhases)
      else $error("phase beyond last write phase");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(phase_ff) && $stable(shift_ff))
      else $error("engine advanced while result was stalled");

endmodule

// File: hdl/i2c_master_byte_engine.sv
// I2C master byte engine: one result word per request word, at one word per clock unless a
// stalled result holds it. A word goes into a QueueDepth-entry queue at the edge it is
// accepted; the bus engine pops it once its result slot is free or being drained, and its
// state registers, updated at that pop, show the result. The bus engine performs one phase
// step per tick word and holds its result in its own state registers; a stalled result
// holds the engine while the queue keeps taking words until it is full.
module i2c_master_byte_engine #(
   parameter int QueueDepth = i2cm_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic       req_send_nack,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl,
   output logic       rsp_sda_out,
   output logic       rsp_sda_oe,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_ack_ok,
   output logic [7:0] rsp_read_data
);

   logic                 push, pop, q_full, q_valid;
   i2cm_pkg::q_word_type push_word, pop_word;

   // Front end: accept and classify
   i2cm_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_send_nack (req_send_nack),
      .req_sda_in    (req_sda_in),
      .q_full        (q_full),
      .push          (push),
      .push_word     (push_word)
   );

   // Decoupling queue
   i2cm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .not_empty (q_valid),
      .full      (q_full)
   );

   // Bus engine and result register
   i2cm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_word        (pop_word),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl       (rsp_scl),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_sda_oe    (rsp_sda_oe),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_ack_ok    (rsp_ack_ok),
      .rsp_read_data (rsp_read_data)
   );

endmodule

// File: bench/i2c_master_byte_engine_tb.sv
// Self-checking testbench for the I2C master byte engine: line-level predictor and stimulus.
package i2cm_bench_pkg;

   // Line levels and status carried by one result word
   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_oe;
      logic       busy;
      logic       done;
      logic       ack_ok;
      logic [7:0] read_data;
   } bus_levels_type;

   // Tracks the bus engine word by word and checks the returned line levels
   class bus_line_predictor;
      logic [5:0]        phase;
      i2cm_pkg::cmd_type kind;
      logic              busy;
      logic [7:0]        shifter;
      logic              nack;
      logic              scl;
      logic              sda;
      logic              oe;
      logic              ack;
      logic [7:0]        rd_byte;
      bus_levels_type    levels_due[$];
      int                errors;

      function new();
         phase   = '0;
         kind    = i2cm_pkg::CMD_START;
         busy    = 1'b0;
         shifter = '0;
         nack    = 1'b0;
         scl     = 1'b0;
         sda     = 1'b1;
         oe      = 1'b1;
         ack     = 1'b0;
         rd_byte = '0;
         errors  = 0;
      endfunction

      function int bus_phases(i2cm_pkg::cmd_type k);
         case (k)
            i2cm_pkg::CMD_WRITE: return 27;
            i2cm_pkg::CMD_READ:  return 19;
            default:             return 4;
         endcase
      endfunction

      // Start and stop: the two differ only in the SDA levels, which are inverted
      function void edge_step(logic [5:0] p, logic fin);
         if (p == 0) begin
            oe  = 1'b1;
            sda = ~fin;
         end else if (p == 1) begin
            scl = 1'b1;
         end else if (p == 2) begin
            sda = fin;
         end else begin
            scl = 1'b0;
         end
         phase = p + 1;
      endfunction

      // Eight data bits of three phases each, then the acknowledge slot
      function void write_step(logic [5:0] p, logic line);
         if (p < 24) begin
            case (p % 3)
               0: sda = shifter[7];
               1: scl = 1'b1;
               default: begin
                  scl     = 1'b0;
                  shifter = shifter << 1;
                  if (p == 23)
                     oe = 1'b0;
               end
            endcase
            phase = p + 1;
         end else if (p == 24) begin
            scl   = 1'b1;
            phase = 25;
         end else if (p == 25) begin
            if (line) begin
               scl   = 1'b0;
               sda   = 1'b1;
               oe    = 1'b1;
               ack   = 1'b0;
               phase = 27;
            end else begin
               sda   = 1'b0;
               oe    = 1'b1;
               ack   = 1'b1;
               phase = 26;
            end
         end else begin
            scl   = 1'b0;
            phase = 27;
         end
      endfunction

      // Eight sampled bits, then ACK or NACK driven by the master
      function void read_step(logic [5:0] p, logic line);
         if (p < 16) begin
            if (!p[0]) begin
               if (p == 0)
                  oe = 1'b0;
               scl = 1'b1;
            end else begin
               shifter = {shifter[6:0], line};
               scl     = 1'b0;
            end
         end else if (p == 16) begin
            oe  = 1'b1;
            sda = nack;
         end else if (p == 17) begin
            scl = 1'b1;
         end else begin
            scl = 1'b0;
         end
         phase = p + 1;
      endfunction

      // Apply one accepted request word and queue the levels it must produce
      function void take_request(logic [2:0] op, logic [7:0] data, logic nack_in, logic line);
         logic           done;
         logic [5:0]     p;
         bus_levels_type w;
         done = 1'b0;
         if (!busy) begin
            if (op <= i2cm_pkg::OP_READ) begin
               kind  = i2cm_pkg::cmd_type'(op[1:0]);
               busy  = 1'b1;
               phase = '0;
               if (op == i2cm_pkg::OP_WRITE) begin
                  shifter = data;
               end else if (op == i2cm_pkg::OP_READ) begin
                  shifter = '0;
                  nack    = nack_in;
               end
            end
         end else if (op == i2cm_pkg::OP_TICK) begin
            p = phase;
            if (p >= bus_phases(kind)) begin
               done = 1'b1;
               busy = 1'b0;
               if (kind == i2cm_pkg::CMD_READ)
                  rd_byte = shifter;
            end else begin
               case (kind)
                  i2cm_pkg::CMD_START: edge_step(p, 1'b0);
                  i2cm_pkg::CMD_STOP:  edge_step(p, 1'b1);
                  i2cm_pkg::CMD_WRITE: write_step(p, line);
                  default:             read_step(p, line);
               endcase
            end
         end
         w = '{scl: scl, sda_out: sda, sda_oe: oe, busy: busy, done: done,
               ack_ok: ack, read_data: rd_byte};
         levels_due.push_back(w);
      endfunction

      function void flag_error(string msg);
         errors++;
         if (errors <= 10)
            $display("MISMATCH: %s", msg);
      endfunction

      // Compare one returned word against the oldest expected levels
      function void check_levels(bus_levels_type got);
         bus_levels_type exp;
         if (levels_due.size() == 0) begin
            flag_error($sformatf({"unexpected word scl=%0d sda=%0d oe=%0d busy=%0d",
                                  " done=%0d ack=%0d rd=%02h"},
                                 got.scl, got.sda_out, got.sda_oe, got.busy, got.done,
                                 got.ack_ok, got.read_data));
            return;
         end
         exp = levels_due.pop_front();
         if (got.scl !== exp.scl || got.sda_out !== exp.sda_out ||
             got.sda_oe !== exp.sda_oe || got.busy !== exp.busy ||
             got.done !== exp.done || got.ack_ok !== exp.ack_ok ||
             got.read_data !== exp.read_data)
            flag_error($sformatf({"exp scl=%0d sda=%0d oe=%0d busy=%0d done=%0d",
                                  " ack=%0d rd=%02h",
                                  " | got scl=%0d sda=%0d oe=%0d busy=%0d done=%0d",
                                  " ack=%0d rd=%02h"},
                                 exp.scl, exp.sda_out, exp.sda_oe, exp.busy, exp.done,
                                 exp.ack_ok, exp.read_data, got.scl, got.sda_out, got.sda_oe,
                                 got.busy, got.done, got.ack_ok, got.read_data));
      endfunction

      function int pending();
         return levels_due.size();
      endfunction
   endclass
endpackage

module i2c_master_byte_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {LINES_LOW, LINES_HIGH, LINES_RANDOM} line_mode_type;

   localparam int StuckLimit = 3000;
   localparam int ItemTarget = 1150;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_op = '0;
   logic [7:0] req_data_byte = '0;
   logic       req_send_nack = 1'b0;
   logic       req_sda_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl;
   logic       rsp_sda_out;
   logic       rsp_sda_oe;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic       rsp_ack_ok;
   logic [7:0] rsp_read_data;

   i2cm_bench_pkg::bus_line_predictor levels = new();

   int send_idle_pct = 27;
   int recv_idle_pct = 52;
   int items_done = 0;
   int words_back = 0;
   int hold_left = 0;
   bit hold_fired = 1'b0;
   int stuck = 0;

   i2c_master_byte_engine u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_send_nack (req_send_nack),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl       (rsp_scl),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_sda_oe    (rsp_sda_oe),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_ack_ok    (rsp_ack_ok),
      .rsp_read_data (rsp_read_data)
   );

   always #1 clock = ~clock;

   // Offer one request word from a falling edge and hold it until accepted
   task automatic send_word(input logic [2:0] op, input logic [7:0] data,
                            input logic nack, input logic line);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= data;
      req_send_nack <= nack;
      req_sda_in    <= line;
      forever begin
         @(posedge clock);
         if (!req_stall)
            break;
      end
      levels.take_request(op, data, nack, line);
      @(negedge clock);
   endtask

   function automatic logic pick_line(line_mode_type mode);
      case (mode)
         LINES_LOW:  return 1'b0;
         LINES_HIGH: return 1'b1;
         default:    return 1'($urandom_range(1));
      endcase
   endfunction

   // Idle noise: ticks and unused op codes while nothing is in progress
   task automatic send_idle_noise();
      send_word(3'($urandom_range(7, 4)), 8'($urandom_range(255)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // One command followed by ticks until it reports done
   task automatic run_command(input i2cm_pkg::cmd_type kind, input logic [7:0] data,
                              input logic nack, input line_mode_type mode,
                              input int noise_pct);
      int         guard;
      logic [2:0] stray;
      send_word({1'b0, kind}, data, nack, pick_line(mode));
      items_done++;
      guard = 0;
      while (levels.busy && guard < 200) begin
         if ($urandom_range(99) < noise_pct) begin
            // anything but a tick is ignored while busy
            stray = 3'($urandom_range(6));
            if (stray >= i2cm_pkg::OP_TICK)
               stray = stray + 1;
            send_word(stray, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
         end else begin
            send_word(i2cm_pkg::OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      pick_line(mode));
            items_done++;
         end
         guard++;
      end
   endtask

   // Receiver: random stalls plus one long hold-off to fill the block
   always @(negedge clock) begin
      if (!hold_fired && words_back >= 500) begin
         hold_fired = 1'b1;
         hold_left  = 200;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Check each accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         levels.check_levels('{scl: rsp_scl, sda_out: rsp_sda_out, sda_oe: rsp_sda_oe,
                               busy: rsp_busy_res, done: rsp_done_res, ack_ok: rsp_ack_ok,
                               read_data: rsp_read_data});
         words_back++;
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck = 0;
      end else begin
         stuck++;
         if (stuck >= StuckLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int            stage;
      int            r;
      line_mode_type mode;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: an idle tick, unused codes, each command at its extremes
      send_word(i2cm_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
      send_word(3'd5, 8'hFF, 1'b1, 1'b0);
      send_word(3'd7, 8'h5A, 1'b0, 1'b1);
      run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, LINES_RANDOM, 0);
      run_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, LINES_LOW, 0);
      run_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, LINES_HIGH, 0);
      run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b0, LINES_HIGH, 0);
      run_command(i2cm_pkg::CMD_READ, 8'hFF, 1'b1, LINES_LOW, 0);
      run_command(i2cm_pkg::CMD_STOP, 8'hA5, 1'b1, LINES_RANDOM, 40);

      // Random transfers in three idling stages
      while (items_done < ItemTarget) begin
         stage = items_done * 3 / ItemTarget;
         if (stage == 0) begin
            send_idle_pct = 27;
            recv_idle_pct = 52;
         end else if (stage == 1) begin
            send_idle_pct = 52;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         r = $urandom_range(99);
         if (r < 6) begin
            send_idle_noise();
         end else begin
            r = $urandom_range(9);
            mode = (r == 0) ? LINES_LOW : (r == 1) ? LINES_HIGH : LINES_RANDOM;
            run_command(i2cm_pkg::cmd_type'($urandom_range(3)), 8'($urandom_range(255)),
                        1'($urandom_range(1)), mode, ($urandom_range(3) == 0) ? 8 : 0);
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow the pipeline latency to show any stray word
      while (levels.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (levels.errors == 0 && levels.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
